FILE: hdl/cte_pkg.sv
// Package for the clock time digit editor: transfer payload types, state
// record, command codes and the digit helper functions.
// No dependencies.
`default_nettype none

package cte_pkg;

	// Command codes carried in the cmd field
	typedef enum logic [2:0] {
		CMD_REFRESH  = 3'd0,
		CMD_BEGIN    = 3'd1,
		CMD_NEXT     = 3'd2,
		CMD_INC      = 3'd3,
		CMD_DEC      = 3'd4,
		CMD_SAVE     = 3'd5
	} cmd_t;

	localparam logic [15:0] REFRESH_RESET  = 16'd1000;
	localparam logic [4:0]  HOUR_LAST      = 5'd23;
	localparam logic [6:0]  HOUR_MAX_FIELD = 7'd31;
	localparam logic [6:0]  MIN_MAX_FIELD  = 7'd63;
	localparam logic [3:0]  HOUR_TENS_MOD  = 4'd3;
	localparam logic [3:0]  MIN_TENS_MOD   = 4'd6;
	localparam logic [3:0]  ERR_COLUMN_2   = 4'b0010;

	// Edit positions
	localparam logic [1:0] POS_HOUR_TENS = 2'd0;
	localparam logic [1:0] POS_HOUR_ONES = 2'd1;
	localparam logic [1:0] POS_MIN_TENS  = 2'd2;
	localparam logic [1:0] POS_MIN_ONES  = 2'd3;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] now_ms;
		logic [4:0]  rtc_hour;
		logic [5:0]  rtc_minute;
		logic        rtc_write_ok;
	} in_item_t;

	typedef struct packed {
		logic [15:0] display_digits;
		logic [15:0] edit_digits;
		logic [3:0]  selected_column;
		logic [3:0]  save_error;
		logic        write_request;
		logic [4:0]  write_hour;
		logic [5:0]  write_minute;
	} out_item_t;

	typedef struct packed {
		logic [4:0]  shown_hour;
		logic [5:0]  shown_minute;
		logic [4:0]  edit_hour;
		logic [5:0]  edit_minute;
		logic [1:0]  edit_position;
		logic [31:0] last_refresh_ms;
	} state_t;

	// Tens digit of a value up to 127 (only values below 70 occur)
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [3:0] t;
		if (v >= 7'd60)      t = 4'd6;
		else if (v >= 7'd50) t = 4'd5;
		else if (v >= 7'd40) t = 4'd4;
		else if (v >= 7'd30) t = 4'd3;
		else if (v >= 7'd20) t = 4'd2;
		else if (v >= 7'd10) t = 4'd1;
		else                 t = 4'd0;
		return t;
	endfunction

	function automatic logic [3:0] ones_of(input logic [6:0] v);
		logic [6:0] r;
		r = v - ({3'b000, tens_of(v)} * 7'd10);
		return r[3:0];
	endfunction

	// Four digits, hour tens in the lowest nibble
	function automatic logic [15:0] pack_digits(input logic [4:0] hour,
	                                            input logic [5:0] minute);
		logic [6:0] h;
		logic [6:0] m;
		h = {2'b00, hour};
		m = {1'b0, minute};
		return {ones_of(m), tens_of(m), ones_of(h), tens_of(h)};
	endfunction

	// Step one digit of a value, wrapping that digit alone, then clamp
	function automatic logic [6:0] step_digit(input logic [6:0] v,
	                                          input logic       tens_digit,
	                                          input logic       up,
	                                          input logic [3:0] tens_mod,
	                                          input logic [6:0] max_val);
		logic [3:0] t;
		logic [3:0] o;
		logic [3:0] t_inc;
		logic [6:0] nv;
		t     = tens_of(v);
		o     = ones_of(v);
		t_inc = t + 4'd1;
		if (tens_digit) begin
			if (up)
				t = (t_inc >= tens_mod) ? t_inc - tens_mod : t_inc;
			else
				t = (t == 4'd0) ? tens_mod - 4'd1 : t - 4'd1;
		end else begin
			if (up)
				o = (o == 4'd9) ? 4'd0 : o + 4'd1;
			else
				o = (o == 4'd0) ? 4'd9 : o - 4'd1;
		end
		nv = ({3'b000, t} * 7'd10) + {3'b000, o};
		return (nv > max_val) ? max_val : nv;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/clock_time_digit_editor.sv
// A result passes through the input register and then the result register,
// and a stalled output can hold it in the input register. Throughput: one
// item per cycle while the output is not stalled; a stalled output holds the
// result while one more item waits in the input register. Reset clears the
// held times, edit position and refresh stamp, and sets the refresh interval
// to 1000 ms.
// Top level of the clock time digit editor; depends on cte_pkg and cte_core.
`default_nettype none

module clock_time_digit_editor (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire cte_pkg::in_item_t    in_data,
	output logic                      out_valid,
	input  wire                       out_stall,
	output cte_pkg::out_item_t        out_data,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [15:0]          cfg_data
);

	logic               valid_s1;
	cte_pkg::in_item_t  item_s1;
	cte_pkg::state_t    state_q;
	cte_pkg::state_t    state_nxt;
	cte_pkg::out_item_t res;
	logic [15:0]        interval_q;
	logic               advance;

	// Configuration register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			interval_q <= cte_pkg::REFRESH_RESET;
		else if (cfg_valid && cfg_ready)
			interval_q <= cfg_data;
	end

	// Flow control: stage 1 moves on when the result register is free
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
	end

	cte_core u_core (
		.item     (item_s1),
		.cur      (state_q),
		.interval (interval_q),
		.nxt      (state_nxt),
		.res      (res)
	);

	// Editor state commits as the result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= '0;
		else if (advance)
			state_q <= state_nxt;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (advance)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data <= res;
	end

	// Checks
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result missing after stage advance");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled while pipeline has room");

	a_column_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(out_data.selected_column))
		else $error("selected column not one-hot");

	a_req_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.write_request && out_data.save_error != 4'd0))
		else $error("write request together with save error");

	a_write_hour_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.write_request) |-> (out_data.write_hour <= cte_pkg::HOUR_LAST))
		else $error("write request with invalid hour");

endmodule

`default_nettype wire

FILE: hdl/cte_core.sv
// Next-state and result logic of the clock time digit editor for one item.
// Depends on cte_pkg (types, command codes, digit helpers).
`default_nettype none

module cte_core (
	input  wire cte_pkg::in_item_t  item,
	input  wire cte_pkg::state_t    cur,
	input  wire logic [15:0]        interval,
	output cte_pkg::state_t         nxt,
	output cte_pkg::out_item_t      res
);

	logic [31:0] elapsed;
	logic        refresh_due;
	logic        up;
	logic [6:0]  hour_step;
	logic [6:0]  min_step;
	logic [3:0]  err;
	logic        req;
	logic [4:0]  wr_hour;
	logic [5:0]  wr_min;

	// Refresh gate, modulo 2^32 elapsed time
	assign elapsed     = item.now_ms - cur.last_refresh_ms;
	assign refresh_due = (elapsed >= {16'd0, interval});

	// Digit steppers for the selected field
	assign up        = (item.cmd == cte_pkg::CMD_INC);
	assign hour_step = cte_pkg::step_digit({2'b00, cur.edit_hour},
		cur.edit_position == cte_pkg::POS_HOUR_TENS, up,
		cte_pkg::HOUR_TENS_MOD, cte_pkg::HOUR_MAX_FIELD);
	assign min_step  = cte_pkg::step_digit({1'b0, cur.edit_minute},
		cur.edit_position == cte_pkg::POS_MIN_TENS, up,
		cte_pkg::MIN_TENS_MOD, cte_pkg::MIN_MAX_FIELD);

	// Command decode
	always_comb begin
		nxt     = cur;
		err     = 4'd0;
		req     = 1'b0;
		wr_hour = 5'd0;
		wr_min  = 6'd0;
		unique case (cte_pkg::cmd_t'(item.cmd))
			cte_pkg::CMD_REFRESH: begin
				if (refresh_due) begin
					nxt.last_refresh_ms = item.now_ms;
					nxt.shown_hour      = item.rtc_hour;
					nxt.shown_minute    = item.rtc_minute;
				end
			end
			cte_pkg::CMD_BEGIN: begin
				nxt.edit_hour     = item.rtc_hour;
				nxt.edit_minute   = item.rtc_minute;
				nxt.edit_position = cte_pkg::POS_HOUR_TENS;
			end
			cte_pkg::CMD_NEXT: begin
				nxt.edit_position = cur.edit_position + 2'd1;
			end
			cte_pkg::CMD_INC, cte_pkg::CMD_DEC: begin
				if (cur.edit_position == cte_pkg::POS_HOUR_TENS ||
				    cur.edit_position == cte_pkg::POS_HOUR_ONES)
					nxt.edit_hour = hour_step[4:0];
				else
					nxt.edit_minute = min_step[5:0];
			end
			cte_pkg::CMD_SAVE: begin
				if (cur.edit_hour > cte_pkg::HOUR_LAST) begin
					err = cte_pkg::ERR_COLUMN_2;
				end else begin
					req     = 1'b1;
					wr_hour = cur.edit_hour;
					wr_min  = cur.edit_minute;
					if (item.rtc_write_ok) begin
						nxt.shown_hour   = cur.edit_hour;
						nxt.shown_minute = cur.edit_minute;
					end
				end
			end
			default: ;
		endcase
	end

	// Result shows the state after the command
	always_comb begin
		res.display_digits  = cte_pkg::pack_digits(nxt.shown_hour, nxt.shown_minute);
		res.edit_digits     = cte_pkg::pack_digits(nxt.edit_hour, nxt.edit_minute);
		res.selected_column = 4'b0001 << nxt.edit_position;
		res.save_error      = err;
		res.write_request   = req;
		res.write_hour      = wr_hour;
		res.write_minute    = wr_min;
	end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for clock_time_digit_editor: directed edit table, then
// random command traffic over several refresh intervals, checked by a predictor.
// Depends on cte_pkg and the editor RTL.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Command codes the block leaves unused
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	localparam int ITEMS_PER_PHASE = 275;
	localparam int HOLD_CYCLES     = 64;
	localparam int WATCHDOG_LIMIT  = 1000;

	typedef struct packed {
		cte_pkg::in_item_t  stim;
		logic               typed;
		cte_pkg::out_item_t want;
	} edit_case_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	cte_pkg::in_item_t  in_data   = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	cte_pkg::out_item_t out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [15:0]        cfg_data  = '0;

	// Predicted editor state
	logic [4:0]  disp_hour;
	logic [5:0]  disp_min;
	logic [4:0]  ed_hour;
	logic [5:0]  ed_min;
	logic [1:0]  ed_pos;
	logic [31:0] refresh_stamp;
	logic [15:0] refresh_gap;

	cte_pkg::out_item_t pending_results [$];
	int          mismatch_count = 0;
	int          results_seen   = 0;
	int          idle_cycles    = 0;
	logic        send_quiet     = 1'b0;
	logic        recv_quiet     = 1'b0;
	logic        hold_off       = 1'b0;
	edit_case_t  edit_cases [25];

	clock_time_digit_editor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Digit layout: hour tens in the low nibble, minute ones on top
	function automatic logic [15:0] digits_of(input int h, input int m);
		return {4'(m % 10), 4'(m / 10), 4'(h % 10), 4'(h / 10)};
	endfunction

	// Step one digit with its own wrap, then clamp to the field
	function automatic int bump_digit(input int v, input logic on_tens, input logic up,
	                                  input int tens_mod, input int ceiling);
		int t;
		int o;
		int s;
		t = v / 10;
		o = v % 10;
		if (on_tens)
			t = up ? (t + 1) % tens_mod : (t == 0 ? tens_mod - 1 : t - 1);
		else
			o = up ? (o + 1) % 10 : (o == 0 ? 9 : o - 1);
		s = t * 10 + o;
		return (s > ceiling) ? ceiling : s;
	endfunction

	// Advance the predicted state by one command and return the result it shows
	function automatic cte_pkg::out_item_t editor_after(input cte_pkg::in_item_t it);
		cte_pkg::out_item_t r;
		logic               up;
		r = '0;
		case (it.cmd)
			cte_pkg::CMD_REFRESH: begin
				if (it.now_ms - refresh_stamp >= 32'(refresh_gap)) begin
					refresh_stamp = it.now_ms;
					disp_hour     = it.rtc_hour;
					disp_min      = it.rtc_minute;
				end
			end
			cte_pkg::CMD_BEGIN: begin
				ed_hour = it.rtc_hour;
				ed_min  = it.rtc_minute;
				ed_pos  = cte_pkg::POS_HOUR_TENS;
			end
			cte_pkg::CMD_NEXT: ed_pos = ed_pos + 2'd1;
			cte_pkg::CMD_INC, cte_pkg::CMD_DEC: begin
				up = (it.cmd == cte_pkg::CMD_INC);
				case (ed_pos)
					cte_pkg::POS_HOUR_TENS: ed_hour = 5'(bump_digit(ed_hour, 1'b1, up,
						cte_pkg::HOUR_TENS_MOD, cte_pkg::HOUR_MAX_FIELD));
					cte_pkg::POS_HOUR_ONES: ed_hour = 5'(bump_digit(ed_hour, 1'b0, up,
						cte_pkg::HOUR_TENS_MOD, cte_pkg::HOUR_MAX_FIELD));
					cte_pkg::POS_MIN_TENS: ed_min = 6'(bump_digit(ed_min, 1'b1, up,
						cte_pkg::MIN_TENS_MOD, cte_pkg::MIN_MAX_FIELD));
					default: ed_min = 6'(bump_digit(ed_min, 1'b0, up,
						cte_pkg::MIN_TENS_MOD, cte_pkg::MIN_MAX_FIELD));
				endcase
			end
			cte_pkg::CMD_SAVE: begin
				if (ed_hour > cte_pkg::HOUR_LAST) begin
					r.save_error = cte_pkg::ERR_COLUMN_2;
				end else begin
					r.write_request = 1'b1;
					r.write_hour    = ed_hour;
					r.write_minute  = ed_min;
					if (it.rtc_write_ok) begin
						disp_hour = ed_hour;
						disp_min  = ed_min;
					end
				end
			end
			default: ;
		endcase
		r.display_digits  = digits_of(disp_hour, disp_min);
		r.edit_digits     = digits_of(ed_hour, ed_min);
		r.selected_column = 4'b0001 << ed_pos;
		return r;
	endfunction

	function automatic edit_case_t row(input logic [2:0] c, input logic [31:0] now,
	                                   input logic [4:0] h, input logic [5:0] m,
	                                   input logic ok, input logic typed,
	                                   input cte_pkg::out_item_t want);
		edit_case_t e;
		e.stim  = '{c, now, h, m, ok};
		e.typed = typed;
		e.want  = want;
		return e;
	endfunction

	// Typed result with no write request
	function automatic cte_pkg::out_item_t shown_only(input logic [15:0] disp,
	                                                  input logic [15:0] edit,
	                                                  input logic [3:0] sel,
	                                                  input logic [3:0] err);
		return '{disp, edit, sel, err, 1'b0, 5'd0, 6'd0};
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
	                             input logic [63:0] want);
		$display("%0t result %0d %s: got %0h want %0h", $time, results_seen, what, got, want);
		mismatch_count++;
	endtask

	// One input transfer; the expectation is queued at the accepting edge
	task automatic send_item(input cte_pkg::in_item_t it, input logic typed,
	                         input cte_pkg::out_item_t typed_want);
		int                 gap;
		cte_pkg::out_item_t want;
		gap = send_quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		want = editor_after(it);
		pending_results.push_back(typed ? typed_want : want);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic set_refresh_interval(input logic [15:0] v);
		drain_results();
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		refresh_gap  = v;
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int n;
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			n = recv_quiet ? 0 : $urandom_range(0, 8);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		cte_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				flag_mismatch("result with nothing pending", out_data, 0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.display_digits !== want.display_digits)
					flag_mismatch("display_digits", out_data.display_digits, want.display_digits);
				if (out_data.edit_digits !== want.edit_digits)
					flag_mismatch("edit_digits", out_data.edit_digits, want.edit_digits);
				if (out_data.selected_column !== want.selected_column)
					flag_mismatch("selected_column", out_data.selected_column,
						want.selected_column);
				if (out_data.save_error !== want.save_error)
					flag_mismatch("save_error", out_data.save_error, want.save_error);
				if (out_data.write_request !== want.write_request)
					flag_mismatch("write_request", out_data.write_request, want.write_request);
				if (out_data.write_hour !== want.write_hour)
					flag_mismatch("write_hour", out_data.write_hour, want.write_hour);
				if (out_data.write_minute !== want.write_minute)
					flag_mismatch("write_minute", out_data.write_minute, want.write_minute);
			end
		end
	end

	// Watchdog on cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		cte_pkg::in_item_t it;
		logic [31:0]       tick;
		logic [15:0]       phase_gap [6];
		int                r;

		disp_hour     = '0;
		disp_min      = '0;
		ed_hour       = '0;
		ed_min        = '0;
		ed_pos        = cte_pkg::POS_HOUR_TENS;
		refresh_stamp = '0;
		refresh_gap   = cte_pkg::REFRESH_RESET;

		// Directed edit walk: refresh timing, digit wraps, clamps, save paths
		edit_cases[0]  = row(CMD_SPARE_HI, 0, 0, 0, 0, 1,
			shown_only(16'h0000, 16'h0000, 4'b0001, 0));
		edit_cases[1]  = row(cte_pkg::CMD_REFRESH, 999, 12, 34, 0, 1,
			shown_only(16'h0000, 16'h0000, 4'b0001, 0));
		edit_cases[2]  = row(cte_pkg::CMD_REFRESH, 1000, 23, 59, 0, 1,
			shown_only(16'h9532, 16'h0000, 4'b0001, 0));
		edit_cases[3]  = row(cte_pkg::CMD_REFRESH, 1999, 5, 5, 0, 1,
			shown_only(16'h9532, 16'h0000, 4'b0001, 0));
		edit_cases[4]  = row(cte_pkg::CMD_BEGIN, 0, 31, 63, 0, 1,
			shown_only(16'h9532, 16'h3613, 4'b0001, 0));
		edit_cases[5]  = row(cte_pkg::CMD_NEXT, 0, 0, 0, 0, 0, '0);
		edit_cases[6]  = row(cte_pkg::CMD_INC, 0, 0, 0, 0, 0, '0);  // hour clamps at 31
		edit_cases[7]  = row(cte_pkg::CMD_NEXT, 0, 0, 0, 0, 0, '0);
		edit_cases[8]  = row(cte_pkg::CMD_NEXT, 0, 0, 0, 0, 0, '0);
		edit_cases[9]  = row(cte_pkg::CMD_INC, 0, 0, 0, 0, 0, '0);  // minute clamps at 63
		edit_cases[10] = row(cte_pkg::CMD_NEXT, 0, 0, 0, 0, 0, '0); // position wraps to hour tens
		edit_cases[11] = row(cte_pkg::CMD_INC, 0, 0, 0, 0, 0, '0);  // tens 3 wraps to 1
		edit_cases[12] = row(cte_pkg::CMD_DEC, 0, 0, 0, 0, 0, '0);
		edit_cases[13] = row(cte_pkg::CMD_DEC, 0, 0, 0, 0, 0, '0);  // tens 0 wraps to 2
		edit_cases[14] = row(cte_pkg::CMD_NEXT, 0, 0, 0, 0, 0, '0);
		edit_cases[15] = row(cte_pkg::CMD_INC, 0, 0, 0, 0, 0, '0);
		edit_cases[16] = row(cte_pkg::CMD_INC, 0, 0, 0, 0, 0, '0);
		edit_cases[17] = row(cte_pkg::CMD_SAVE, 0, 0, 0, 0, 0, '0); // write refused, display kept
		edit_cases[18] = row(cte_pkg::CMD_INC, 0, 0, 0, 0, 0, '0);
		edit_cases[19] = row(cte_pkg::CMD_SAVE, 0, 0, 0, 1, 1,
			shown_only(16'h9532, 16'h3642, 4'b0010, cte_pkg::ERR_COLUMN_2));
		edit_cases[20] = row(cte_pkg::CMD_DEC, 0, 0, 0, 0, 0, '0);
		edit_cases[21] = row(cte_pkg::CMD_SAVE, 0, 0, 0, 1, 0, '0); // minute 63 written as is
		edit_cases[22] = row(cte_pkg::CMD_REFRESH, 32'hFFFF_FFFF, 0, 0, 0, 1,
			shown_only(16'h0000, 16'h3632, 4'b0010, 0));
		edit_cases[23] = row(cte_pkg::CMD_REFRESH, 0, 7, 7, 0, 0, '0); // elapsed 1 across the wrap
		edit_cases[24] = row(CMD_SPARE_LO, 32'hFFFF_FFFF, 31, 63, 1, 0, '0);

		phase_gap[0] = 16'd0;
		phase_gap[1] = 16'hFFFF;
		phase_gap[2] = 16'd1;
		phase_gap[3] = 16'($urandom_range(2, 65534));
		phase_gap[4] = cte_pkg::REFRESH_RESET;
		phase_gap[5] = 16'd250;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (edit_cases[i])
			send_item(edit_cases[i].stim, edit_cases[i].typed, edit_cases[i].want);

		tick = 32'd0;
		for (int p = 0; p < 6; p++) begin
			set_refresh_interval(phase_gap[p]);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k % 40 == 0 && !(p == 1 && k >= 100 && k < 130)) begin
					send_quiet = ($urandom_range(0, 3) == 0);
					recv_quiet = ($urandom_range(0, 3) == 0);
				end
				// Long result hold-off while items keep coming
				if (p == 1 && k == 100) begin
					hold_off   = 1'b1;
					send_quiet = 1'b1;
				end
				// Sender pause until everything is back
				if (p == 3 && k == 150)
					drain_results();

				r = $urandom_range(0, 99);
				if (r < 4)
					tick = $urandom;
				else if (r < 6)
					tick = 32'hFFFF_FFFF - $urandom_range(0, 3000);
				else
					tick = tick + $urandom_range(0, 2 * refresh_gap + 2);

				r = $urandom_range(0, 99);
				if (r < 18)      it.cmd = cte_pkg::CMD_REFRESH;
				else if (r < 26) it.cmd = cte_pkg::CMD_BEGIN;
				else if (r < 42) it.cmd = cte_pkg::CMD_NEXT;
				else if (r < 64) it.cmd = cte_pkg::CMD_INC;
				else if (r < 86) it.cmd = cte_pkg::CMD_DEC;
				else if (r < 97) it.cmd = cte_pkg::CMD_SAVE;
				else             it.cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
				it.now_ms       = tick;
				it.rtc_hour     = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 23))
				                                               : 5'($urandom_range(24, 31));
				it.rtc_minute   = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 59))
				                                               : 6'($urandom_range(60, 63));
				it.rtc_write_ok = 1'($urandom_range(0, 1));
				send_item(it, 1'b0, '0);
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
hdl/cte_pkg.sv
hdl/cte_core.sv
hdl/clock_time_digit_editor.sv
dv/tb.sv
